// ----- design/dtwl_pkg.sv -----
// Shared constants, types and state codes for the tuning word serial loader.
package dtwl_pkg;

   localparam int WORD_BITS  = 32;
   localparam int CTRL_BITS  = 8;
   localparam int TOTAL_BITS = WORD_BITS + CTRL_BITS;
   localparam int FREQ_W     = 28;
   localparam int PHASE_W    = 5;
   localparam int NUM_W      = FREQ_W + 1;           // freq + IF offset
   localparam int REF_W      = 31;                   // osc * 6 < 2^31
   localparam int DIVR_W     = REF_W + 1;            // divisor is 2 * ref
   localparam int DIVD_W     = NUM_W + WORD_BITS + 1; // (num << 33) + ref
   localparam int STEPS      = 2;                    // quotient bits per cycle
   localparam int DIV_CYCLES = DIVD_W / STEPS;
   localparam int ITER_W     = $clog2(DIV_CYCLES);
   localparam int BITNUM_W   = 6;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int CSR_IDX_W  = 2;

   localparam logic [BITNUM_W-1:0] LAST_BIT   = BITNUM_W'(TOTAL_BITS - 1);
   localparam logic [ITER_W-1:0]   LAST_ITER  = ITER_W'(DIV_CYCLES - 1);
   localparam logic [QCNT_W-1:0]   QFULL      = QCNT_W'(QDEPTH);

   localparam logic [CSR_IDX_W-1:0] REG_OSC   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IF    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MULT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE = 2'd3;

   localparam logic [FREQ_W-1:0]  OSC_RESET   = 28'd30000000;

   typedef struct packed {
      logic [NUM_W-1:0]     num;
      logic [REF_W-1:0]     refclk;
      logic                 zero_ref;
      logic [CTRL_BITS-1:0] ctrl;
   } job_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [CTRL_BITS-1:0] ctrl;
   } result_type;

   typedef enum logic [2:0] {
      DIV_IDLE = 3'b001,
      DIV_RUN  = 3'b010,
      DIV_DONE = 3'b100
   } div_state_type;

endpackage

// ----- design/dtwl_front.sv -----
// Front end: CSRs, item intake, reference/numerator setup and a short job queue.
module dtwl_front import dtwl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FREQ_W-1:0]    csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FREQ_W-1:0]    req_freq_hz,
   output logic                 job_valid,
   input  logic                 job_ready,
   output job_type              job
);

   logic [FREQ_W-1:0]  osc_ff, osc_in;
   logic [FREQ_W-1:0]  if_ff, if_in;
   logic               mult_ff, mult_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;

   job_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   logic               push, pop;
   job_type            new_job;
   logic [REF_W-1:0]   osc_ext;

   assign csr_ready = 1'b1;

   always_comb begin
      osc_in   = osc_ff;
      if_in    = if_ff;
      mult_in  = mult_ff;
      phase_in = phase_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_OSC:   osc_in   = csr_data;
            REG_IF:    if_in    = csr_data;
            REG_MULT:  mult_in  = csr_data[0];
            REG_PHASE: phase_in = csr_data[PHASE_W-1:0];
            default: ;
         endcase
      end
   end

   // ref = osc * 6 as two shifted adds when the multiplier is on, else osc
   assign osc_ext = REF_W'(osc_ff);
   always_comb begin
      new_job.num      = NUM_W'(req_freq_hz) + NUM_W'(if_ff);
      new_job.refclk   = mult_ff ? (osc_ext << 2) + (osc_ext << 1) : osc_ext;
      new_job.zero_ref = (osc_ff == '0);
      new_job.ctrl     = {phase_ff, 2'b00, mult_ff};
   end

   assign req_stall = (count_ff == QFULL);
   assign push      = req_valid & ~req_stall;
   assign job_valid = (count_ff != '0);
   assign pop       = job_valid & job_ready;
   assign job       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         osc_ff    <= OSC_RESET;
         if_ff     <= '0;
         mult_ff   <= 1'b1;
         phase_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         osc_ff    <= osc_in;
         if_ff     <= if_in;
         mult_ff   <= mult_in;
         phase_ff  <= phase_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QFULL)
      else $error("job queue count out of range");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("job queue count did not drop on pop");

endmodule

// ----- design/dtwl_divider.sv -----
// Iterative restoring divider forming the rounded 32-bit tuning word.
module dtwl_divider import dtwl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   output logic       job_ready,
   input  job_type    job,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res
);

   div_state_type         state_ff, state_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [DIVD_W-1:0]     divd_ff, divd_in;
   logic [DIVR_W-1:0]     divr_ff, divr_in;
   logic [DIVR_W-1:0]     rem_ff, rem_in;
   logic [WORD_BITS-1:0]  quo_ff, quo_in;
   logic [CTRL_BITS-1:0]  ctrl_ff, ctrl_in;

   logic [DIVR_W:0]       trial1, trial2;
   logic [DIVR_W-1:0]     rem1, rem2;
   logic                  qbit1, qbit2;

   // two restoring steps per cycle
   always_comb begin
      trial1 = {rem_ff, divd_ff[DIVD_W-1]};
      qbit1  = (trial1 >= {1'b0, divr_ff});
      rem1   = qbit1 ? DIVR_W'(trial1 - {1'b0, divr_ff}) : trial1[DIVR_W-1:0];
      trial2 = {rem1, divd_ff[DIVD_W-2]};
      qbit2  = (trial2 >= {1'b0, divr_ff});
      rem2   = qbit2 ? DIVR_W'(trial2 - {1'b0, divr_ff}) : trial2[DIVR_W-1:0];
   end

   assign job_ready = (state_ff == DIV_IDLE);
   assign res_valid = (state_ff == DIV_DONE);
   assign res.word  = quo_ff;
   assign res.ctrl  = ctrl_ff;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      divd_in  = divd_ff;
      divr_in  = divr_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ctrl_in  = ctrl_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (job_valid) begin
               ctrl_in = job.ctrl;
               divd_in = {job.num, (WORD_BITS + 1)'(0)} | DIVD_W'(job.refclk);
               divr_in = {job.refclk, 1'b0};
               rem_in  = '0;
               iter_in = '0;
               if (job.zero_ref) begin
                  quo_in   = '1;
                  state_in = DIV_DONE;
               end else begin
                  state_in = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            rem_in  = rem2;
            divd_in = divd_ff << STEPS;
            quo_in  = {quo_ff[WORD_BITS-STEPS-1:0], qbit1, qbit2};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == LAST_ITER) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (res_ready) begin
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      divd_ff <= divd_in;
      divr_ff <= divr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      ctrl_ff <= ctrl_in;
   end

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN && iter_ff == LAST_ITER) |=> (state_ff == DIV_DONE))
      else $error("divider did not finish after last iteration");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_DONE && divr_ff != '0) |-> (rem_ff < divr_ff))
      else $error("divider remainder not below divisor");

endmodule

// ----- design/dtwl_serializer.sv -----
// Back end: shifts tuning word and control byte out LSB first, one beat per bit.
module dtwl_serializer import dtwl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   output logic                res_ready,
   input  result_type          res,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_serial_bit,
   output logic [BITNUM_W-1:0] rsp_bit_number,
   output logic                rsp_last
);

   logic                      busy_ff, busy_in;
   logic [TOTAL_BITS-1:0]     shift_ff, shift_in;
   logic [BITNUM_W-1:0]       cnt_ff, cnt_in;
   logic                      beat_done, finishing;

   assign beat_done = busy_ff & ~rsp_stall;
   assign finishing = beat_done & (cnt_ff == LAST_BIT);
   assign res_ready = ~busy_ff | finishing;

   always_comb begin
      busy_in  = busy_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (res_ready & res_valid) begin
         busy_in  = 1'b1;
         shift_in = {res.ctrl, res.word};
         cnt_in   = '0;
      end else if (finishing) begin
         busy_in = 1'b0;
      end else if (beat_done) begin
         shift_in = shift_ff >> 1;
         cnt_in   = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign rsp_valid      = busy_ff;
   assign rsp_serial_bit = shift_ff[0];
   assign rsp_bit_number = cnt_ff;
   assign rsp_last       = (cnt_ff == LAST_BIT);

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= LAST_BIT))
      else $error("bit counter past last bit");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (beat_done && !rsp_last) |=> (rsp_valid && rsp_bit_number == $past(cnt_ff) + 1'b1))
      else $error("serial frame broken mid-word");

endmodule

// ----- design/dds_tuning_word_serial_loader_core.sv -----
// Top level of the DDS tuning word serial loader.
//
// req_ channel: one beat carries a frequency in Hz (req_freq_hz). The loader
// adds the IF offset, divides by the reference (oscillator, times six when the
// multiplier is on) and rounds half up to a 32-bit tuning word.
// rsp_ channel: 40 beats per request, word bits 0..31 then control byte bits
// 32..39 (bit 0 multiplier enable, bits 3..7 phase code), LSB first;
// rsp_last marks bit 39.
// csr_ channel: index 0 osc_hz, 1 if_offset_hz, 2 mult_enable, 3 phase_code;
// always ready, write only while the loader is idle.
// A request passes through the job queue, then the two-bit-per-cycle divider
// (load and run) and the hand-off to the serializer before its first rsp beat.
// The serializer puts out one bit per cycle while rsp_stall is low; the
// divider works on the next word while bits go out.
// A two-entry queue sits in front of the divider; req_stall rises when full.
// Reset (synchronous) restores osc 30 MHz, IF 0, multiplier on, phase 0, and
// empties the queue. While rsp_stall is high the current bit holds.
module dds_tuning_word_serial_loader_core import dtwl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FREQ_W-1:0]    csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FREQ_W-1:0]    req_freq_hz,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_serial_bit,
   output logic [BITNUM_W-1:0]  rsp_bit_number,
   output logic                 rsp_last
);

   logic       job_valid, job_ready;
   job_type    job;
   logic       res_valid, res_ready;
   result_type res;

   dtwl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_freq_hz (req_freq_hz),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job)
   );

   dtwl_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   dtwl_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_serial_bit (rsp_serial_bit),
      .rsp_bit_number (rsp_bit_number),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- tb/dds_tuning_word_serial_loader_core_tb.sv -----
// Self-checking testbench for the DDS tuning word serial loader core.
`timescale 1ns / 100ps

module dds_tuning_word_serial_loader_core_tb;
   import dtwl_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 6;
   localparam int LOADS_PER_PHASE = 85;
   localparam logic [FREQ_W-1:0] FREQ_TOP = 28'd180000000;

   typedef struct packed {
      logic                sbit;
      logic [BITNUM_W-1:0] pos;
      logic                last;
   } serial_beat_type;

   // directed step: either a register write or a frequency load
   typedef struct packed {
      logic                 is_write;
      logic [CSR_IDX_W-1:0] idx;
      logic [FREQ_W-1:0]    value;
      logic                 typed;
      logic [WORD_BITS-1:0] word;
   } step_type;

   localparam int PLAN_LEN = 25;

   step_type plan [PLAN_LEN] = '{
      '{1'b0, REG_OSC,   28'd0,         1'b1, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'd90000000,  1'b1, 32'h8000_0000},
      '{1'b0, REG_OSC,   28'd180000000, 1'b1, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'hFFFFFFF,   1'b0, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'd1,         1'b1, 32'd24},
      '{1'b1, REG_PHASE, 28'hFFFFFFF,   1'b0, 32'h0000_0000},
      '{1'b1, REG_MULT,  28'hFFFFFFE,   1'b0, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'd30000000,  1'b1, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'd15000000,  1'b1, 32'h8000_0000},
      '{1'b1, REG_IF,    28'hFFFFFFF,   1'b0, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'hFFFFFFF,   1'b0, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'd0,         1'b0, 32'h0000_0000},
      '{1'b1, REG_OSC,   28'd0,         1'b0, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'd12345,     1'b1, 32'hFFFF_FFFF},
      '{1'b1, REG_MULT,  28'd1,         1'b0, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'hFFFFFFF,   1'b1, 32'hFFFF_FFFF},
      '{1'b1, REG_OSC,   28'hFFFFFFF,   1'b0, 32'h0000_0000},
      '{1'b1, REG_IF,    28'd0,         1'b0, 32'h0000_0000},
      '{1'b1, REG_PHASE, 28'h0000015,   1'b0, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'd0,         1'b1, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'hFFFFFFF,   1'b0, 32'h0000_0000},
      '{1'b1, REG_OSC,   28'd1,         1'b0, 32'h0000_0000},
      '{1'b1, REG_MULT,  28'd0,         1'b0, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'd7,         1'b1, 32'h0000_0000},
      '{1'b0, REG_OSC,   28'h5555555,   1'b1, 32'h0000_0000}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FREQ_W-1:0]    csr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [FREQ_W-1:0]    req_freq_hz;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_serial_bit;
   logic [BITNUM_W-1:0]  rsp_bit_number;
   logic                 rsp_last;

   // shadow copy of the loader's registers
   logic [FREQ_W-1:0]  cfg_osc;
   logic [FREQ_W-1:0]  cfg_if;
   logic               cfg_mult;
   logic [PHASE_W-1:0] cfg_phase;

   serial_beat_type pending_bits[$];

   bit req_gaps_on;
   bit rsp_stalls_on;
   int stall_left;
   int idle_cycles;
   int errors;
   int loads_sent;
   int beats_checked;
   int writes_done;

   dds_tuning_word_serial_loader_core dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_freq_hz    (req_freq_hz),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_serial_bit (rsp_serial_bit),
      .rsp_bit_number (rsp_bit_number),
      .rsp_last       (rsp_last)
   );

   always #4 clock = ~clock;

   // round half up of (freq + IF) * 2^32 / ref, wrapped to 32 bits; all ones for a zero ref
   function automatic logic [WORD_BITS-1:0] ftw_for(input logic [FREQ_W-1:0] freq);
      logic [63:0] num;
      logic [63:0] refclk;
      logic [63:0] q;
      num    = 64'(freq) + 64'(cfg_if);
      refclk = 64'(cfg_osc) * (cfg_mult ? 64'd6 : 64'd1);
      if (refclk == 64'd0)
         return '1;
      q = ((num << 33) + refclk) / (refclk << 1);
      return q[WORD_BITS-1:0];
   endfunction

   function automatic void queue_load(input logic [WORD_BITS-1:0] word);
      logic [CTRL_BITS-1:0] ctrl;
      serial_beat_type      b;
      ctrl = {cfg_phase, 2'b00, cfg_mult};
      for (int k = 0; k < TOTAL_BITS; k++) begin
         b.sbit = (k < WORD_BITS) ? word[k] : ctrl[k - WORD_BITS];
         b.pos  = BITNUM_W'(k);
         b.last = (k == TOTAL_BITS - 1);
         pending_bits.push_back(b);
      end
   endfunction

   function automatic logic [FREQ_W-1:0] draw_freq();
      int pick;
      pick = $urandom_range(0, 15);
      case (pick)
         0: return '0;
         1: return FREQ_TOP;
         2: return FREQ_W'($urandom);
         default: return FREQ_W'($urandom_range(0, 180000000));
      endcase
   endfunction

   function automatic void report(input string what, input int unsigned expv,
                                  input int unsigned actv);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, expv, actv);
   endfunction

   // all tasks below start and end at a falling edge
   task automatic send_freq(input logic [FREQ_W-1:0] freq, input logic typed,
                            input logic [WORD_BITS-1:0] word);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 7) : 0;
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_freq_hz <= freq;
      do @(posedge clock); while (req_stall);
      queue_load(typed ? word : ftw_for(freq));
      loads_sent++;
      @(negedge clock);
   endtask

   // leaves csr_valid high; the next send or drain lowers it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [FREQ_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_OSC:   cfg_osc   = data;
         REG_IF:    cfg_if    = data;
         REG_MULT:  cfg_mult  = data[0];
         REG_PHASE: cfg_phase = data[PHASE_W-1:0];
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (pending_bits.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic load_settings(input logic [FREQ_W-1:0] osc, input logic [FREQ_W-1:0] ifo,
                                input logic [FREQ_W-1:0] mult, input logic [FREQ_W-1:0] ph);
      write_reg(REG_OSC, osc);
      write_reg(REG_IF, ifo);
      write_reg(REG_MULT, mult);
      write_reg(REG_PHASE, ph);
   endtask

   // result side: check each beat, then pick the stall that follows it; also the idle watchdog
   always @(posedge clock) begin
      serial_beat_type exp_b;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            stall_left = rsp_stalls_on ? $urandom_range(0, 7) : 0;
            if (pending_bits.size() == 0) begin
               report("unexpected beat, bit_number", 0, rsp_bit_number);
            end else begin
               exp_b = pending_bits.pop_front();
               if (rsp_serial_bit !== exp_b.sbit)
                  report("serial_bit", exp_b.sbit, rsp_serial_bit);
               if (rsp_bit_number !== exp_b.pos)
                  report("bit_number", exp_b.pos, rsp_bit_number);
               if (rsp_last !== exp_b.last)
                  report("last", exp_b.last, rsp_last);
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d beats outstanding",
                     $time, WATCHDOG_LIMIT, pending_bits.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      logic [FREQ_W-1:0] osc;
      logic [FREQ_W-1:0] ifo;
      logic [FREQ_W-1:0] mult;
      logic [FREQ_W-1:0] ph;
      bit prev_write;

      clock         = 1'b0;
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_freq_hz   = '0;
      rsp_stall     = 1'b0;
      stall_left    = 0;
      idle_cycles   = 0;
      errors        = 0;
      loads_sent    = 0;
      beats_checked = 0;
      writes_done   = 0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      prev_write    = 1'b0;
      cfg_osc       = OSC_RESET;
      cfg_if        = '0;
      cfg_mult      = 1'b1;
      cfg_phase     = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed steps: reset values, extremes, zero reference, wraparound
      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            if (!prev_write)
               drain(8);
            write_reg(plan[i].idx, plan[i].value);
         end else begin
            send_freq(plan[i].value, plan[i].typed, plan[i].word);
         end
         prev_write = plan[i].is_write;
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin osc = OSC_RESET; ifo = '0; mult = 28'd1; ph = '0; end
            1: begin osc = FREQ_TOP; ifo = FREQ_TOP; mult = 28'd1; ph = 28'd31; end
            2: begin osc = '1; ifo = '1; mult = '1; ph = '1; end
            3: begin
               osc  = FREQ_W'($urandom_range(1, 1000));
               ifo  = FREQ_W'($urandom_range(0, 180000000));
               mult = '0;
               ph   = FREQ_W'($urandom_range(0, 31));
            end
            4: begin
               osc  = FREQ_W'($urandom_range(1000000, 180000000));
               ifo  = FREQ_W'($urandom_range(0, 180000000));
               mult = FREQ_W'($urandom_range(0, 1));
               ph   = FREQ_W'($urandom);
            end
            default: begin
               osc  = FREQ_W'($urandom);
               ifo  = FREQ_W'($urandom);
               mult = FREQ_W'($urandom);
               ph   = FREQ_W'($urandom);
            end
         endcase
         // vary back pressure: some phases run without request gaps, others without rsp stalls
         req_gaps_on   = (p % 3 != 1);
         rsp_stalls_on = (p % 3 != 2);
         drain(8);
         load_settings(osc, ifo, mult, ph);
         for (int n = 0; n < LOADS_PER_PHASE; n++)
            send_freq(draw_freq(), 1'b0, '0);
      end

      drain(50);
      $display("Checked %0d frequency loads (%0d serial beats) over %0d register writes,",
               loads_sent, beats_checked, writes_done);
      $display("including zero reference, word wrap and out-of-range register values.");
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
